FILE: src/hft_pkg.sv
// Package for the hashed flow table: types, codes and hash constants.
// No dependencies.
`default_nettype none
package hft_pkg;
	localparam logic [31:0] HASH_BASIS = 32'h811C9DC5;
	localparam logic [31:0] HASH_MULT  = 32'h01000193;

	typedef enum logic [1:0] {
		ST_NEW  = 2'd0,
		ST_UPD  = 2'd1,
		ST_DROP = 2'd2,
		ST_READ = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_MOD,
		S_RD,
		S_CHK,
		S_OUT
	} fsm_t;

	typedef struct packed {
		logic        op;
		logic [63:0] key_low;
		logic [63:0] key_high;
		logic [31:0] packet_bytes;
		logic [47:0] timestamp;
		logic [9:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        slot_valid;
		logic [63:0] slot_key_low;
		logic [63:0] slot_key_high;
		logic [31:0] slot_packets;
		logic [63:0] slot_byte_total;
		logic [47:0] slot_first_seen;
		logic [47:0] slot_last_seen;
		logic [10:0] flow_total;
		logic [31:0] probe_total;
		logic [31:0] drop_total;
	} rsp_t;

	// slot record held in memory
	typedef struct packed {
		logic [127:0] key;
		logic [31:0]  pkts;
		logic [63:0]  bytes;
		logic [47:0]  first;
		logic [47:0]  last;
	} slot_t;
endpackage
`default_nettype wire

FILE: src/hft_if.sv
// Valid/ready channel carrying one item of type T.
// No dependencies; the payload type is the parameter T.
`default_nettype none
interface hft_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/hashed_flow_table_update.sv
// Flow accounting table: FNV-1a hash, linear probing in a slot memory.
// Depends on hft_pkg and hft_if.
//
//  channel | dir | payload | handshake
//  req     | in  | req_t   | valid/ready
//  rsp     | out | rsp_t   | valid/ready
//
// Read item: the slot is read (S_RD), checked (S_CHK) and the result registered
// (S_OUT). Update: each key byte is hashed (multiply, then load), the hash is
// reduced to a home slot, each probed slot is read and compared, then output.
// The next item is taken the cycle after the result leaves.
// After reset a clearing pass empties the valid memory; no item is taken
// during it. The output register holds a result until taken.
`default_nettype none
module hashed_flow_table_update import hft_pkg::*; #(
	parameter int CAPACITY  = 1024,
	parameter int MAX_PROBE = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	hft_if.sink      req,
	hft_if.source    rsp
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW = $clog2(MAX_PROBE + 1);
	// floor(2^32 / CAPACITY): quotient estimate is low by at most one
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / CAPACITY);
	localparam logic [31:0] CAP32 = 32'(CAPACITY);

	fsm_t        state_q, state_d;
	req_t        req_q;
	logic [31:0] hash_q;
	logic [3:0]  byte_q;
	logic [31:0] prod_q;
	logic        mul_ph_q;
	logic [1:0]  mod_ph_q;
	logic [AW-1:0] idx_q;
	logic [PW-1:0] dist_q;
	logic [AW:0]   clr_q;
	logic          clr_busy;
	logic [10:0] flows_q;
	logic [31:0] probe_q;
	logic [31:0] drop_q;
	rsp_t        out_q;
	logic        out_vld_q;

	// slot memories: active bits and records, registered read
	logic        act_mem [CAPACITY];
	slot_t       rec_mem [CAPACITY];
	logic        act_rd_s1;
	slot_t       rec_rd_s1;
	logic        act_we, rec_we;
	logic [AW-1:0] wr_addr, rd_addr;
	logic        act_wd;
	slot_t       rec_wd;

	logic [7:0]  cur_byte;
	logic        hit, in_range;
	logic [63:0] recip_prod;

	assign clr_busy  = !clr_q[AW] && (clr_q < CAPACITY[AW:0]);
	assign req.ready = (state_q == S_IDLE) && !out_vld_q && !clr_busy;
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	assign cur_byte = byte_q[3] ? req_q.key_high[{byte_q[2:0], 3'b000} +: 8]
		: req_q.key_low[{byte_q[2:0], 3'b000} +: 8];
	assign hit = rec_rd_s1.key == {req_q.key_high, req_q.key_low};
	assign in_range = {22'd0, req_q.slot_index} < CAPACITY;
	assign recip_prod = {32'd0, hash_q} * {32'd0, RECIP};
	assign rd_addr = idx_q;

	always_ff @(posedge clk) begin
		if (act_we) act_mem[wr_addr] <= act_wd;
		if (rec_we) rec_mem[wr_addr] <= rec_wd;
		act_rd_s1 <= act_mem[rd_addr];
		rec_rd_s1 <= rec_mem[rd_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req.valid && req.ready) state_d = req.data.op ? S_RD : S_HASH;
			S_HASH: if (mul_ph_q && byte_q == 4'd15) state_d = S_MOD;
			S_MOD:  if (mod_ph_q == 2'd2) state_d = S_RD;
			S_RD:   state_d = S_CHK;
			S_CHK: begin
				if (req_q.op || !act_rd_s1 || hit || dist_q == PW'(MAX_PROBE - 1))
					state_d = S_OUT;
				else
					state_d = S_RD;
			end
			S_OUT:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory write control
	always_comb begin
		act_we = 1'b0;
		rec_we = 1'b0;
		act_wd = 1'b1;
		wr_addr = idx_q;
		rec_wd = rec_rd_s1;
		if (clr_busy) begin
			act_we = 1'b1;
			act_wd = 1'b0;
			wr_addr = clr_q[AW-1:0];
		end else if (state_q == S_CHK && !req_q.op) begin
			if (!act_rd_s1) begin
				act_we = 1'b1;
				rec_we = 1'b1;
				rec_wd = '{key: {req_q.key_high, req_q.key_low}, pkts: 32'd1,
					bytes: {32'd0, req_q.packet_bytes}, first: req_q.timestamp,
					last: req_q.timestamp};
			end else if (hit) begin
				rec_we = 1'b1;
				rec_wd.pkts  = rec_rd_s1.pkts + 32'd1;
				rec_wd.bytes = rec_rd_s1.bytes + {32'd0, req_q.packet_bytes};
				rec_wd.last  = req_q.timestamp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			clr_q     <= '0;
			flows_q   <= '0;
			probe_q   <= '0;
			drop_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_busy) clr_q <= clr_q + (AW+1)'(1);
			if (rsp.valid && rsp.ready) out_vld_q <= 1'b0;
			if (state_q == S_CHK && !req_q.op) begin
				if (!act_rd_s1) begin
					flows_q <= flows_q + 11'd1;
					probe_q <= probe_q + 32'(dist_q);
				end else if (hit) begin
					probe_q <= probe_q + 32'(dist_q);
				end else if (dist_q == PW'(MAX_PROBE - 1)) begin
					drop_q <= drop_q + 32'd1;
				end
			end
			if (state_q == S_OUT) out_vld_q <= 1'b1;
		end
	end

	// datapath: hash, home slot, probe index, result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q    <= req.data;
				hash_q   <= HASH_BASIS;
				byte_q   <= '0;
				mul_ph_q <= 1'b0;
				mod_ph_q <= '0;
				dist_q   <= '0;
				idx_q    <= AW'(req.data.slot_index);
			end
			S_HASH: begin
				mul_ph_q <= !mul_ph_q;
				if (!mul_ph_q) begin
					prod_q <= (hash_q ^ {24'd0, cur_byte}) * HASH_MULT;
				end else begin
					hash_q <= prod_q;
					byte_q <= byte_q + 4'd1;
				end
			end
			// hash modulo CAPACITY: reciprocal quotient, remainder, one correction
			S_MOD: begin
				mod_ph_q <= mod_ph_q + 2'd1;
				case (mod_ph_q)
					2'd0: prod_q <= recip_prod[63:32];
					2'd1: prod_q <= hash_q - prod_q * CAP32;
					default: idx_q <= (prod_q >= CAP32) ? AW'(prod_q - CAP32) : AW'(prod_q);
				endcase
			end
			S_CHK: begin
				if (!req_q.op && act_rd_s1 && !hit) begin
					dist_q <= dist_q + PW'(1);
					idx_q  <= (32'(idx_q) == CAPACITY - 1) ? '0 : idx_q + AW'(1);
				end
				out_q <= '0;
				if (req_q.op) begin
					out_q.status <= ST_READ;
					if (in_range && act_rd_s1) begin
						out_q.slot_valid      <= 1'b1;
						out_q.slot_key_low    <= rec_rd_s1.key[63:0];
						out_q.slot_key_high   <= rec_rd_s1.key[127:64];
						out_q.slot_packets    <= rec_rd_s1.pkts;
						out_q.slot_byte_total <= rec_rd_s1.bytes;
						out_q.slot_first_seen <= rec_rd_s1.first;
						out_q.slot_last_seen  <= rec_rd_s1.last;
					end
				end else if (!act_rd_s1) out_q.status <= ST_NEW;
				else if (hit) out_q.status <= ST_UPD;
				else out_q.status <= ST_DROP;
			end
			S_OUT: begin
				out_q.flow_total  <= flows_q;
				out_q.probe_total <= probe_q;
				out_q.drop_total  <= drop_q;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: src/hft_checker.sv
// Port-level checks for hashed_flow_table_update, bound to the top level.
// Depends on hft_pkg.
`default_nettype none
module hft_checker import hft_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire rsp_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("item taken while result pending");
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid && !in_ready)
		else $error("result too early");
	a_drop_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_DROP |-> out_data.slot_valid == 1'b0)
		else $error("drop shows slot");
endmodule

bind hashed_flow_table_update hft_checker u_hft_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
);
`default_nettype wire

FILE: tb/sv/tb_hashed_flow_table_update.sv
// Self-checking testbench for the hashed flow table: FNV-1a hashing, linear probing, reads.
// Depends on hft_pkg, hft_if and the hashed_flow_table_update block.
`default_nettype none
module tb_hashed_flow_table_update;
	timeunit 1ns;
	timeprecision 1ps;
	import hft_pkg::*;

	localparam int CAP   = 1024;
	localparam int PROBE = 16;
	localparam int IDLE_LIMIT = 200000;

	logic clk;
	logic arst_n;

	hft_if #(.T(req_t)) req (.clk(clk));
	hft_if #(.T(rsp_t)) rsp (.clk(clk));

	hashed_flow_table_update #(.CAPACITY(CAP), .MAX_PROBE(PROBE)) u_dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	// table image kept by the predictor
	logic         tbl_active [CAP];
	logic [127:0] tbl_key    [CAP];
	logic [31:0]  tbl_pkts   [CAP];
	logic [63:0]  tbl_bytes  [CAP];
	logic [47:0]  tbl_first  [CAP];
	logic [47:0]  tbl_last   [CAP];
	logic [10:0]  flows;
	logic [31:0]  probes;
	logic [31:0]  drops;

	rsp_t expected_rsps[$];
	int   mismatches;
	int   idle_cycles;
	bit   timed_out;
	bit   rx_hold;
	int   hold_cycles;
	logic [127:0] known_keys[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] fnv1a_128(input logic [127:0] key);
		logic [31:0] h;
		h = HASH_BASIS;
		for (int i = 0; i < 16; i++) begin
			h = h ^ {24'd0, key[i*8 +: 8]};
			h = h * HASH_MULT;
		end
		return h;
	endfunction

	// apply one item to the table image and return the result it should give
	function automatic rsp_t predict_flow(input req_t r);
		rsp_t o;
		logic [127:0] key;
		int idx;
		bit done;
		o = '0;
		key = {r.key_high, r.key_low};
		done = 1'b0;
		if (r.op) begin
			o.status = ST_READ;
			if (r.slot_index < CAP && tbl_active[r.slot_index]) begin
				o.slot_valid      = 1'b1;
				o.slot_key_low    = tbl_key[r.slot_index][63:0];
				o.slot_key_high   = tbl_key[r.slot_index][127:64];
				o.slot_packets    = tbl_pkts[r.slot_index];
				o.slot_byte_total = tbl_bytes[r.slot_index];
				o.slot_first_seen = tbl_first[r.slot_index];
				o.slot_last_seen  = tbl_last[r.slot_index];
			end
		end else begin
			idx = fnv1a_128(key) % CAP;
			for (int d = 0; d < PROBE && !done; d++) begin
				if (!tbl_active[idx]) begin
					tbl_active[idx] = 1'b1;
					tbl_key[idx]    = key;
					tbl_pkts[idx]   = 32'd1;
					tbl_bytes[idx]  = {32'd0, r.packet_bytes};
					tbl_first[idx]  = r.timestamp;
					tbl_last[idx]   = r.timestamp;
					flows  = flows + 11'd1;
					probes = probes + 32'(d);
					o.status = ST_NEW;
					done = 1'b1;
				end else if (tbl_key[idx] == key) begin
					tbl_pkts[idx]  = tbl_pkts[idx] + 32'd1;
					tbl_bytes[idx] = tbl_bytes[idx] + {32'd0, r.packet_bytes};
					tbl_last[idx]  = r.timestamp;
					probes = probes + 32'(d);
					o.status = ST_UPD;
					done = 1'b1;
				end else begin
					idx = (idx + 1) % CAP;
				end
			end
			if (!done) begin
				drops = drops + 32'd1;
				o.status = ST_DROP;
			end
		end
		o.flow_total  = flows;
		o.probe_total = probes;
		o.drop_total  = drops;
		return o;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// send one item; the prediction is made when it is accepted.
	// With no gap, valid stays high into the next item; wait_drained drops it.
	task automatic send_item(input req_t r);
		int g;
		g = gap_len();
		if (g != 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		expected_rsps.push_back(predict_flow(r));
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	function automatic req_t update_item(input logic [127:0] key);
		req_t r;
		r = '0;
		r.op = 1'b0;
		r.key_low = key[63:0];
		r.key_high = key[127:64];
		r.packet_bytes = $urandom();
		r.timestamp = rand48();
		r.slot_index = 10'($urandom_range(0, CAP - 1));
		return r;
	endfunction

	function automatic req_t read_item(input logic [9:0] s);
		req_t r;
		r = '0;
		r.op = 1'b1;
		r.key_low = rand64();
		r.key_high = rand64();
		r.packet_bytes = $urandom();
		r.timestamp = rand48();
		r.slot_index = s;
		return r;
	endfunction

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (expected_rsps.size() != 0 && !timed_out) @(posedge clk);
	endtask

	// key whose hash lands at a chosen home slot, found by search
	function automatic logic [127:0] key_at_home(input int home);
		logic [127:0] k;
		do k = {rand64(), rand64()}; while ((fnv1a_128(k) % CAP) != home);
		return k;
	endfunction

	// field extremes, reads of empty and full slots, repeat updates
	task automatic test_directed();
		logic [127:0] k;
		req_t r;
		send_item(read_item(10'd0));
		send_item(read_item(10'd1023));
		k = '0;
		r = update_item(k); r.packet_bytes = 32'hFFFF_FFFF; r.timestamp = '1;
		send_item(r);
		r.packet_bytes = 32'hFFFF_FFFF; r.timestamp = '0;
		send_item(r);
		send_item(r);
		k = '1;
		r = update_item(k); r.packet_bytes = '0; r.timestamp = '0;
		send_item(r);
		known_keys.push_back('0);
		known_keys.push_back('1);
		for (int s = 0; s < CAP; s += 97) send_item(read_item(s[9:0]));
		send_item(read_item(10'(fnv1a_128('0) % CAP)));
		send_item(read_item(10'(fnv1a_128('1) % CAP)));
	endtask

	// cluster on one home slot: probe distances, wrap past the top, drops
	task automatic test_probe_cluster();
		logic [127:0] k;
		for (int i = 0; i < PROBE + 3; i++) begin
			k = key_at_home(CAP - 3);
			known_keys.push_back(k);
			send_item(update_item(k));
		end
		for (int i = 0; i < 4; i++) send_item(update_item(known_keys[$ - i]));
		for (int i = 0; i < 3; i++) send_item(read_item(i[9:0]));
	endtask

	// updates of known flows, new flows, reads at and just past hashed slots, random reads
	task automatic test_random_mix(input int n);
		logic [127:0] k;
		int p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			if (p < 45 && known_keys.size() != 0) begin
				send_item(update_item(known_keys[$urandom_range(0, known_keys.size() - 1)]));
			end else if (p < 70) begin
				k = {rand64(), rand64()};
				known_keys.push_back(k);
				send_item(update_item(k));
			end else if (p < 85 && known_keys.size() != 0) begin
				k = known_keys[$urandom_range(0, known_keys.size() - 1)];
				send_item(read_item(10'((fnv1a_128(k) % CAP) + $urandom_range(0, 2))));
			end else begin
				send_item(read_item(10'($urandom_range(0, CAP - 1))));
			end
		end
	endtask

	// receiver holds off for a long stretch while items keep coming
	task automatic test_backpressure();
		rx_hold = 1'b1;
		hold_cycles = 0;
		fork
			test_random_mix(30);
			while (hold_cycles < 400) @(posedge clk);
		join_any
		rx_hold = 1'b0;
		wait fork;
		wait_drained();
	endtask

	// receiver: random stalls, or a long hold when asked
	initial begin
		int g;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				hold_cycles++;
				rsp.ready <= 1'b0;
			end else if (rsp.ready && !(rsp.valid)) begin
				rsp.ready <= 1'b1;
			end else begin
				g = gap_len();
				if (g == 0) rsp.ready <= 1'b1;
				else begin
					rsp.ready <= 1'b0;
					repeat (g - 1) @(posedge clk);
					rsp.ready <= 1'b1;
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", rsp.data);
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.data !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", e, rsp.data);
				end
			end
		end
	end

	// watchdog on cycles without any accepted item or result
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			timed_out = 1'b1;
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < CAP; i++) begin
			tbl_active[i] = 1'b0;
			tbl_key[i] = '0; tbl_pkts[i] = '0; tbl_bytes[i] = '0;
			tbl_first[i] = '0; tbl_last[i] = '0;
		end
		flows = '0; probes = '0; drops = '0;
		mismatches = 0; idle_cycles = 0; timed_out = 1'b0;
		rx_hold = 1'b0; hold_cycles = 0;
		req.valid <= 1'b0;
		req.data  <= '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_probe_cluster();
		wait_drained();
		test_backpressure();
		test_random_mix(1550);
		wait_drained();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
